[src/ipvrf_pkg.sv]
// ============================================================================
// IPv4 receive filter package
// Shared constants, header summary type and checksum helper for the IPv4
// receive header check and filter.
// ============================================================================
package ipvrf_pkg;

    // Width of the byte counter; the count saturates at all ones.
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] COUNT_CAP = '1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBNET_MASK   = 1'b1;

    // Verdict status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_VIHL  = 3'd2;
    localparam logic [2:0] ST_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_TOTAL_LEN = 3'd4;
    localparam logic [2:0] ST_NOT_OURS  = 3'd5;
    localparam logic [2:0] ST_FRAGMENT  = 3'd6;
    localparam logic [2:0] ST_UNK_PROTO = 3'd7;

    // Protocol classes.
    localparam logic [1:0] CLS_ICMP  = 2'd0;
    localparam logic [1:0] CLS_UDP   = 2'd1;
    localparam logic [1:0] CLS_TCP   = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Header constants.
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  IHL_MASK      = 4'hF;
    localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
    localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
    localparam logic [31:0] LIMITED_BCAST = 32'hFFFF_FFFF;
    localparam logic [LENGTH_BITS-1:0] HDR_MIN_BYTES = LENGTH_BITS'(20);

    // Byte offsets of the captured header fields.
    localparam logic [LENGTH_BITS-1:0] OFS_VER_IHL  = LENGTH_BITS'(0);
    localparam logic [LENGTH_BITS-1:0] OFS_TOTAL_HI = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] OFS_TOTAL_LO = LENGTH_BITS'(3);
    localparam logic [LENGTH_BITS-1:0] OFS_FRAG_HI  = LENGTH_BITS'(6);
    localparam logic [LENGTH_BITS-1:0] OFS_FRAG_LO  = LENGTH_BITS'(7);
    localparam logic [LENGTH_BITS-1:0] OFS_PROTO    = LENGTH_BITS'(9);
    localparam logic [LENGTH_BITS-1:0] OFS_SRC      = LENGTH_BITS'(12);
    localparam logic [LENGTH_BITS-1:0] OFS_DST      = LENGTH_BITS'(16);
    localparam logic [LENGTH_BITS-1:0] OFS_DST_END  = LENGTH_BITS'(20);

    // Summary of one finished packet, handed from the parser to the checker.
    typedef struct packed {
        logic [LENGTH_BITS-1:0] byte_count;
        logic [15:0]            checksum;
        logic [7:0]             version_ihl;
        logic [15:0]            total_length;
        logic [15:0]            flags_fragment;
        logic [7:0]             protocol;
        logic [31:0]            source;
        logic [31:0]            dest;
    } hdr_snap_t;

    // Ones' complement add of one 16-bit word with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] raw;
        logic [16:0] folded;
        raw    = {1'b0, s} + {1'b0, w};
        folded = {1'b0, raw[15:0]} + {16'd0, raw[16]};
        return folded[15:0];
    endfunction

endpackage

[src/ipv4_receive_filter_core.sv]
// ============================================================================
// IPv4 receive filter core
// Byte-wide IPv4 header checker and destination filter, one verdict word per
// packet.
// ============================================================================
// The core takes one packet byte per cycle on the input channel, unless input
// is held off, and gives one verdict word per packet once the output register
// is free. A byte is folded into the running count, checksum and header
// capture in the cycle it arrives; the last byte moves a packet summary into a
// one-word stage, and the checker turns that into the registered verdict.
// Input is held off only while both the summary stage and the output register
// are full and the output side is not taking a word.
// Write local_address and subnet_mask only while no packet is in flight.
module ipv4_receive_filter_core
    import ipvrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [1:0]             proto_class,
    output logic [31:0]            source_address,
    output logic [31:0]            dest_address,
    output logic [5:0]             header_length,
    output logic [15:0]            payload_length,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic [31:0] local_address_reg;
    logic [31:0] subnet_mask_reg;
    logic        snap_valid;
    logic        snap_take;
    hdr_snap_t   snap;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            subnet_mask_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                CFG_SUBNET_MASK:   subnet_mask_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Byte accumulation and header capture.
    ipvrf_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .snap       (snap)
    );

    // Header checks and verdict register.
    ipvrf_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_valid     (snap_valid),
        .snap_take      (snap_take),
        .snap           (snap),
        .local_address  (local_address_reg),
        .subnet_mask    (subnet_mask_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .proto_class    (proto_class),
        .source_address (source_address),
        .dest_address   (dest_address),
        .header_length  (header_length),
        .payload_length (payload_length)
    );

`ifndef SYNTHESIS
    // A good verdict always carries a full-size header.
    a_ok_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (header_length >= 6'd20))
        else $error("ok verdict with short header length");

    // A rejected packet reports no payload.
    a_reject_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (payload_length == 16'd0))
        else $error("rejected packet with nonzero payload length");

    // A pending packet summary is never dropped before the checker takes it.
    a_snap_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid && !snap_take) |=> snap_valid)
        else $error("packet summary lost");

    // The input side is held off only while the summary stage is occupied.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (snap_valid && out_valid && !out_ready))
        else $error("input stalled without backpressure");
`endif

endmodule

[src/ipvrf_accum.sv]
// ============================================================================
// IPv4 receive filter byte accumulator
// Counts packet bytes, folds header words into the checksum and captures the
// header fields. On the last byte it hands a packet summary to the checker.
// ============================================================================
module ipvrf_accum
    import ipvrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] data_byte,
    input  logic      last_byte,
    output logic      snap_valid,
    input  logic      snap_take,
    output hdr_snap_t snap
);

    // Per-packet working state.
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  vihl_reg, vihl_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    // Summary stage.
    hdr_snap_t snap_reg;
    logic      snap_valid_reg, snap_valid_next;

    logic [5:0] ihl_bytes;
    logic       in_header;
    logic       accept;

    // The summary slot frees up when the checker takes it.
    assign in_ready = !snap_valid_reg || snap_take;
    assign accept   = in_valid && in_ready;

    assign ihl_bytes = {vihl_reg[3:0] & IHL_MASK, 2'b00};
    assign in_header = (count_reg == OFS_VER_IHL) ||
                       (count_reg < LENGTH_BITS'(ihl_bytes));

    // Next working state with the incoming byte folded in.
    always_comb
    begin
        vihl_next  = vihl_reg;
        total_next = total_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        hold_next  = hold_reg;
        sum_next   = sum_reg;

        case (count_reg)
            OFS_VER_IHL:  vihl_next  = data_byte;
            OFS_TOTAL_HI: total_next = {data_byte, total_reg[7:0]};
            OFS_TOTAL_LO: total_next = {total_reg[15:8], data_byte};
            OFS_FRAG_HI:  frag_next  = {data_byte, frag_reg[7:0]};
            OFS_FRAG_LO:  frag_next  = {frag_reg[15:8], data_byte};
            OFS_PROTO:    proto_next = data_byte;
            default:      ;
        endcase

        if (count_reg >= OFS_SRC && count_reg < OFS_DST)
        begin
            src_next = {src_reg[23:0], data_byte};
        end
        if (count_reg >= OFS_DST && count_reg < OFS_DST_END)
        begin
            dst_next = {dst_reg[23:0], data_byte};
        end

        // Even offsets hold the high byte, odd offsets complete a word.
        if (in_header)
        begin
            if (!count_reg[0])
            begin
                hold_next = data_byte;
            end
            else
            begin
                sum_next = ones_add(sum_reg, {hold_reg, data_byte});
            end
        end

        count_next = (count_reg == COUNT_CAP) ? count_reg : count_reg + 1'b1;
    end

    // Working state: updated per accepted byte, cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            vihl_reg  <= '0;
            total_reg <= '0;
            frag_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                vihl_reg  <= '0;
                total_reg <= '0;
                frag_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                vihl_reg  <= vihl_next;
                total_reg <= total_next;
                frag_reg  <= frag_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

    // Summary valid flag.
    always_comb
    begin
        if (accept && last_byte)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Summary payload is loaded with the last byte folded in.
    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            snap_reg.byte_count     <= count_next;
            snap_reg.checksum       <= sum_next;
            snap_reg.version_ihl    <= vihl_next;
            snap_reg.total_length   <= total_next;
            snap_reg.flags_fragment <= frag_next;
            snap_reg.protocol       <= proto_next;
            snap_reg.source         <= src_next;
            snap_reg.dest           <= dst_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

[src/ipvrf_check.sv]
// ============================================================================
// IPv4 receive filter header checker
// Runs the prioritized header checks on a packet summary and registers the
// verdict word for the output channel.
// ============================================================================
module ipvrf_check
    import ipvrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        snap_valid,
    output logic        snap_take,
    input  hdr_snap_t   snap,
    input  logic [31:0] local_address,
    input  logic [31:0] subnet_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [1:0]  proto_class,
    output logic [31:0] source_address,
    output logic [31:0] dest_address,
    output logic [5:0]  header_length,
    output logic [15:0] payload_length
);

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [1:0]  class_reg, class_next;
    logic [31:0] src_reg, dst_reg;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] payload_reg, payload_next;

    logic [31:0] bcast;
    logic [15:0] len16;
    logic [15:0] ihl16;

    // The output register takes a new word when empty or being drained.
    assign snap_take = snap_valid && (!out_valid_reg || out_ready);

    assign ihl_next = {snap.version_ihl[3:0] & IHL_MASK, 2'b00};
    assign bcast    = local_address | ~subnet_mask;
    assign len16    = 16'(snap.byte_count);
    assign ihl16    = 16'(ihl_next);

    // Protocol class from the captured protocol number.
    always_comb
    begin
        case (snap.protocol)
            PROTO_ICMP: class_next = CLS_ICMP;
            PROTO_UDP:  class_next = CLS_UDP;
            PROTO_TCP:  class_next = CLS_TCP;
            default:    class_next = CLS_OTHER;
        endcase
    end

    // Checks in priority order; the first failure sets the status.
    always_comb
    begin
        if (snap.byte_count < HDR_MIN_BYTES)
        begin
            status_next = ST_SHORT;
        end
        else if (snap.version_ihl[7:4] != IP_VERSION ||
                 ihl16 < 16'(HDR_MIN_BYTES) || ihl16 > len16)
        begin
            status_next = ST_BAD_VIHL;
        end
        else if (snap.checksum != SUM_GOOD)
        begin
            status_next = ST_CHECKSUM;
        end
        else if (snap.total_length < ihl16 || snap.total_length > len16)
        begin
            status_next = ST_TOTAL_LEN;
        end
        else if (local_address != '0 && snap.dest != local_address &&
                 snap.dest != LIMITED_BCAST && snap.dest != bcast)
        begin
            status_next = ST_NOT_OURS;
        end
        else if ((snap.flags_fragment & FRAG_MASK) != '0)
        begin
            status_next = ST_FRAGMENT;
        end
        else if (class_next == CLS_OTHER)
        begin
            status_next = ST_UNK_PROTO;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign payload_next = (status_next == ST_OK) ? snap.total_length - ihl16 : '0;

    // Output valid flag.
    always_comb
    begin
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Verdict word.
    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            status_reg  <= status_next;
            class_reg   <= class_next;
            src_reg     <= snap.source;
            dst_reg     <= snap.dest;
            ihl_reg     <= ihl_next;
            payload_reg <= payload_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign proto_class    = class_reg;
    assign source_address = src_reg;
    assign dest_address   = dst_reg;
    assign header_length  = ihl_reg;
    assign payload_length = payload_reg;

endmodule
